[rtl/assert_macros.svh]
// Assertion macros used by the top level of the joystick and mouse port.
// Depends on nothing; the user supplies the clock and reset names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is low.
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/jmp_pkg.sv]
// Package of the joystick and mouse port: command codes, item and control types,
// and the joystick conversion function. Depends on nothing.
package jmp_pkg;

   // Command codes carried in the request tuser.
   localparam logic [2:0] CMD_FRAME     = 3'd0;
   localparam logic [2:0] CMD_PORT_B_WR = 3'd1;
   localparam logic [2:0] CMD_READ      = 3'd2;
   localparam logic [2:0] CMD_MASK_WR   = 3'd3;
   localparam logic [2:0] CMD_TIMEOUT   = 3'd4;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MOUSE_MODE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRN_USE    = 1'b1;

   // Mouse mode codes.
   localparam logic [1:0] MODE_PORT0 = 2'd1;
   localparam logic [1:0] MODE_PORT1 = 2'd2;

   // Printer use codes that select a printer joystick channel.
   localparam logic [1:0] PRN_CH0 = 2'd1;
   localparam logic [1:0] PRN_CH1 = 2'd2;

   // Read address codes.
   localparam logic [1:0] ADDR_PORT = 2'd0;
   localparam logic [1:0] ADDR_PRN0 = 2'd2;
   localparam logic [1:0] ADDR_PRN1 = 2'd3;

   localparam int unsigned REQ_DATA_W = 48;
   localparam logic [7:0]  BYTE_ONES  = 8'hff;
   localparam logic [7:0]  SAT_POS    = 8'sd127;
   localparam logic [7:0]  SAT_NEG    = 8'h81;   // -127

   // One accepted request word.
   typedef struct packed {
      logic [2:0]        cmd;
      logic signed [7:0] dx;
      logic signed [7:0] dy;
      logic [1:0]        buttons;
      logic [7:0]        joy0;
      logic [7:0]        joy1;
      logic [1:0]        addr;
      logic [7:0]        data;
   } item_type;

   // Decoded command strobes for the word being executed.
   typedef struct packed {
      logic frame;
      logic port_b_wr;
      logic mask_wr;
      logic timeout;
   } ctl_type;

   // Mouse view seen by the read path.
   typedef struct packed {
      logic [3:0] nibble;
      logic [1:0] buttons;
   } mouse_view_type;

   // Raw joystick bits to an active-low port word; alternate buttons merge
   // onto the main buttons and the two top bits read as ones.
   function automatic logic [7:0] joy_convert(input logic [7:0] raw);
      logic [7:0] w;
      w = {2'b11, ~raw[5:0]};
      if (raw[6]) w[4] = 1'b0;
      if (raw[7]) w[5] = 1'b0;
      return w;
   endfunction

endpackage

[rtl/jmp_mouse.sv]
// Mouse half of the port: saturating accumulators, button latch and the
// strobe-driven nibble sequence. Depends on jmp_pkg.
module jmp_mouse (
   input  logic                    clock,
   input  logic                    reset,
   input  jmp_pkg::ctl_type        ctl,
   input  jmp_pkg::item_type       item,
   input  logic [1:0]              mouse_mode,
   output jmp_pkg::mouse_view_type view
);
   import jmp_pkg::*;

   logic [7:0] accum_x_ff, accum_x_in, accum_y_ff, accum_y_in;
   logic [7:0] latched_x_ff, latched_x_in, latched_y_ff, latched_y_in;
   logic [1:0] buttons_ff, buttons_in;
   logic       strobe_ff, strobe_in;
   logic [1:0] phase_ff, phase_in;
   logic       level;
   logic       step;

   // Add a delta and clamp to plus or minus 127.
   function automatic logic [7:0] sat_add(input logic [7:0] acc, input logic [7:0] d);
      logic signed [8:0] s;
      s = $signed({acc[7], acc}) + $signed({d[7], d});
      if (s > 9'sd127) return SAT_POS;
      if (s < -9'sd127) return SAT_NEG;
      return s[7:0];
   endfunction

   // The strobe bit depends on which port the mouse sits on.
   assign level = (mouse_mode == MODE_PORT0) ? item.data[4] : item.data[5];
   assign step  = ctl.port_b_wr && (mouse_mode == MODE_PORT0 || mouse_mode == MODE_PORT1)
                  && (level != strobe_ff);

   // Next state of the mouse registers.
   always_comb begin
      accum_x_in   = accum_x_ff;
      accum_y_in   = accum_y_ff;
      latched_x_in = latched_x_ff;
      latched_y_in = latched_y_ff;
      buttons_in   = buttons_ff;
      strobe_in    = strobe_ff;
      phase_in     = phase_ff;
      if (ctl.frame) begin
         accum_x_in = sat_add(accum_x_ff, item.dx);
         accum_y_in = sat_add(accum_y_ff, item.dy);
         buttons_in = ~item.buttons;
      end
      if (step) begin
         strobe_in = level;
         if (phase_ff == 2'd0) begin
            latched_x_in = 8'd0 - accum_x_ff;
            latched_y_in = 8'd0 - accum_y_ff;
            accum_x_in   = 8'd0;
            accum_y_in   = 8'd0;
         end
         phase_in = phase_ff + 2'd1;
      end
      if (ctl.timeout) begin
         phase_in     = 2'd0;
         strobe_in    = 1'b0;
         accum_x_in   = 8'd0;
         accum_y_in   = 8'd0;
         latched_x_in = 8'd0;
         latched_y_in = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_x_ff   <= 8'd0;
         accum_y_ff   <= 8'd0;
         latched_x_ff <= 8'd0;
         latched_y_ff <= 8'd0;
         buttons_ff   <= 2'd0;
         strobe_ff    <= 1'b0;
         phase_ff     <= 2'd0;
      end else begin
         accum_x_ff   <= accum_x_in;
         accum_y_ff   <= accum_y_in;
         latched_x_ff <= latched_x_in;
         latched_y_ff <= latched_y_in;
         buttons_ff   <= buttons_in;
         strobe_ff    <= strobe_in;
         phase_ff     <= phase_in;
      end
   end

   // Nibble presented for the current phase.
   always_comb begin
      unique case (phase_ff)
         2'd1:    view.nibble = latched_x_ff[3:0];
         2'd2:    view.nibble = latched_x_ff[7:4];
         2'd3:    view.nibble = latched_y_ff[3:0];
         default: view.nibble = latched_y_ff[7:4];
      endcase
   end
   assign view.buttons = buttons_ff;

endmodule

[rtl/jmp_port.sv]
// Joystick half of the port and the read multiplexer: port words, raw copies,
// port B and printer mask registers. Depends on jmp_pkg.
module jmp_port (
   input  logic                    clock,
   input  logic                    reset,
   input  jmp_pkg::ctl_type        ctl,
   input  jmp_pkg::item_type       item,
   input  logic [1:0]              mouse_mode,
   input  logic [1:0]              prn_use,
   input  jmp_pkg::mouse_view_type view,
   output logic [7:0]              read_data
);
   import jmp_pkg::*;

   logic [7:0] joy_word_ff [2];
   logic [7:0] raw_copy_ff [2];
   logic [5:0] mask_ff;
   logic [7:0] port_b_ff;
   logic [7:0] raw_sel;
   logic       flag;
   logic [1:0] sel;
   logic       mouse_hit;

   // Frame updates joystick words unless that channel carries the mouse.
   always_ff @(posedge clock) begin
      if (reset) begin
         joy_word_ff[0] <= BYTE_ONES;
         joy_word_ff[1] <= BYTE_ONES;
         raw_copy_ff[0] <= 8'd0;
         raw_copy_ff[1] <= 8'd0;
         mask_ff        <= 6'd0;
         port_b_ff      <= 8'd0;
      end else begin
         if (ctl.frame) begin
            raw_copy_ff[0] <= item.joy0;
            raw_copy_ff[1] <= item.joy1;
            if (mouse_mode != MODE_PORT0) joy_word_ff[0] <= joy_convert(item.joy0);
            if (mouse_mode != MODE_PORT1) joy_word_ff[1] <= joy_convert(item.joy1);
         end
         if (ctl.port_b_wr) port_b_ff <= item.data;
         if (ctl.mask_wr && (prn_use == PRN_CH0 || prn_use == PRN_CH1)) begin
            mask_ff <= item.data[5:0];
         end
      end
   end

   // Mouse select and button gating from port B.
   always_comb begin
      mouse_hit = 1'b0;
      sel       = 2'd0;
      if (mouse_mode == MODE_PORT0) begin
         mouse_hit = (port_b_ff[7:6] == 2'b00);
         sel       = port_b_ff[1:0];
      end else if (mouse_mode == MODE_PORT1) begin
         mouse_hit = (port_b_ff[7:6] == 2'b01);
         sel       = port_b_ff[3:2];
      end
   end

   // Printer joystick flag: any active line whose mask bit is clear.
   assign raw_sel = (item.addr == ADDR_PRN0) ? raw_copy_ff[0] : raw_copy_ff[1];
   assign flag = (raw_sel[3] & ~mask_ff[0]) | (raw_sel[2] & ~mask_ff[1])
               | (raw_sel[0] & ~mask_ff[2]) | (raw_sel[1] & ~mask_ff[3])
               | (raw_sel[5] & ~mask_ff[4]) | (raw_sel[4] & ~mask_ff[5]);

   // Read multiplexer.
   always_comb begin
      read_data = BYTE_ONES;
      unique case (item.addr)
         ADDR_PORT: begin
            if (mouse_hit) begin
               read_data = {2'b11, sel & view.buttons, view.nibble};
            end else if (port_b_ff[7:4] == 4'h2 && prn_use != PRN_CH0) begin
               read_data = joy_word_ff[0];
            end else if (port_b_ff[7:4] == 4'h5 && prn_use != PRN_CH1) begin
               read_data = joy_word_ff[1];
            end
         end
         ADDR_PRN0: begin
            if (prn_use == PRN_CH0 && flag) read_data = 8'h00;
         end
         ADDR_PRN1: begin
            if (prn_use == PRN_CH1 && flag) read_data = 8'h00;
         end
         default: read_data = BYTE_ONES;
      endcase
   end

endmodule

[rtl/joystick_mouse_port.sv]
// Top level of the joystick and mouse port: request register, result register,
// configuration registers. Depends on jmp_pkg, jmp_mouse, jmp_port, assert_macros.svh.
//
//   channel  dir  handshake             payload
//   req      in   req_tvalid/tready     tuser command, tdata item fields
//   rsp      out  rsp_tvalid/tready     tdata read byte
//   csr      in   csr_we                csr_index, csr_wdata
//
// A word is registered on acceptance and executed from the request register: one word
// per cycle sustained unless a read is held, and each read byte is registered for rsp.
// The only stall is a read word held in the request register while the
// result register is full and not taken; other commands never wait.
// Reset is synchronous and clears all control and port state.
`include "assert_macros.svh"

module joystick_mouse_port (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [2:0]                         req_tuser,  // command
   // tdata fields from bit 0: mouse_dx[7:0], mouse_dy[7:0], mouse_buttons[1:0],
   // joy0_raw[7:0], joy1_raw[7:0], address[1:0], data_byte[7:0], zero fill[3:0]
   input  logic [jmp_pkg::REQ_DATA_W-1:0]     req_tdata,
   // Result channel.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [7:0]                         rsp_tdata,  // read_data[7:0]
   // Configuration port.
   input  logic                               csr_we,
   input  logic [jmp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [1:0]                         csr_wdata
);
   import jmp_pkg::*;

   logic           item_valid_ff, item_valid_in;
   item_type       item_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     rsp_data_ff;
   logic [1:0]     mouse_mode_ff;
   logic [1:0]     prn_use_ff;
   logic           is_read;
   logic           advance;
   ctl_type        ctl;
   mouse_view_type view;
   logic [7:0]     read_data;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mouse_mode_ff <= 2'd0;
         prn_use_ff    <= 2'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MOUSE_MODE: mouse_mode_ff <= csr_wdata;
            CSR_PRN_USE:    prn_use_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // A read word needs room in the result register; others go at once.
   assign is_read    = (item_ff.cmd == CMD_READ);
   assign advance    = item_valid_ff && (!is_read || !rsp_valid_ff || rsp_tready);
   assign req_tready = !reset && (!item_valid_ff || advance);

   assign ctl.frame     = advance && (item_ff.cmd == CMD_FRAME);
   assign ctl.port_b_wr = advance && (item_ff.cmd == CMD_PORT_B_WR);
   assign ctl.mask_wr   = advance && (item_ff.cmd == CMD_MASK_WR);
   assign ctl.timeout   = advance && (item_ff.cmd == CMD_TIMEOUT);

   // Request register.
   always_comb begin
      item_valid_in = item_valid_ff;
      if (advance) item_valid_in = 1'b0;
      if (req_tvalid && req_tready) item_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) item_valid_ff <= 1'b0;
      else       item_valid_ff <= item_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.cmd     <= req_tuser;
         item_ff.dx      <= req_tdata[7:0];
         item_ff.dy      <= req_tdata[15:8];
         item_ff.buttons <= req_tdata[17:16];
         item_ff.joy0    <= req_tdata[25:18];
         item_ff.joy1    <= req_tdata[33:26];
         item_ff.addr    <= req_tdata[35:34];
         item_ff.data    <= req_tdata[43:36];
      end
   end

   jmp_mouse u_mouse (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .item       (item_ff),
      .mouse_mode (mouse_mode_ff),
      .view       (view)
   );

   jmp_port u_port (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .item       (item_ff),
      .mouse_mode (mouse_mode_ff),
      .prn_use    (prn_use_ff),
      .view       (view),
      .read_data  (read_data)
   );

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;
      if (advance && is_read) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (advance && is_read) rsp_data_ff <= read_data;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Checks on the request and result registers.
   `ASSERT_RST(a_held_word_stays, clock, reset, item_valid_ff && !advance |=> item_valid_ff, "held request word was lost")
   `ASSERT_RST(a_read_gives_rsp, clock, reset, advance && is_read |=> rsp_valid_ff, "read word produced no result")
   `ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid_ff && !item_valid_ff, "reset left a word in flight")

endmodule

[tb/joystick_mouse_port_tb.sv]
// Self-checking bench for joystick_mouse_port: a directed table, then random words
// under several port settings; every read byte is checked against a literal table
// byte or a behavioral port model. Depends on jmp_pkg and the joystick_mouse_port RTL.
module joystick_mouse_port_tb;
   import jmp_pkg::*;

   // Codes the package leaves unnamed.
   localparam logic [1:0] MODE_NONE  = 2'd0;
   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam logic [1:0] PRN_NONE   = 2'd0;
   localparam logic [1:0] PRN_SPARE  = 2'd3;
   localparam logic [1:0] ADDR_SPARE = 2'd1;
   localparam logic [2:0] CMD_SPARE5 = 3'd5;
   localparam logic [2:0] CMD_SPARE7 = 3'd7;
   localparam int         PREDICT    = -1;   // table row with no literal byte
   localparam int         DRAIN      = 4;    // cycles for a word with no result to retire

   logic                        clock      = 1'b0;
   logic                        reset      = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [2:0]                  req_tuser  = CMD_FRAME;
   logic [REQ_DATA_W-1:0]       req_tdata  = '0;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [7:0]                  rsp_tdata;
   logic                        csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0]      csr_index  = CSR_MOUSE_MODE;
   logic [1:0]                  csr_wdata  = 2'd0;

   logic                        no_gaps    = 1'b0;
   int                          bad_count  = 0;
   logic [7:0]                  read_bytes_due[$];

   joystick_mouse_port DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial forever #10 clock = ~clock;

   initial begin
      #4_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // Port model state, reset values included.
   logic [1:0] cfg_mode  = MODE_NONE;
   logic [1:0] cfg_prn   = PRN_NONE;
   logic [7:0] acc_x     = '0;
   logic [7:0] acc_y     = '0;
   logic [7:0] lat_x     = '0;
   logic [7:0] lat_y     = '0;
   logic [1:0] btn_up    = '0;
   logic       strobe    = 1'b0;
   logic [1:0] phase     = '0;
   logic [7:0] joy_w[2]  = '{8'hff, 8'hff};
   logic [7:0] joy_raw[2] = '{8'h00, 8'h00};
   logic [5:0] prn_mask  = '0;
   logic [7:0] port_b    = '0;

   function automatic logic [7:0] sat_sum(input logic [7:0] a, input logic [7:0] d);
      int s;
      s = $signed(a) + $signed(d);
      if (s > 127) s = 127;
      if (s < -127) s = -127;
      return 8'(s);
   endfunction

   // Active-low port word: alternate buttons pull the main button bits low too.
   function automatic logic [7:0] port_word(input logic [7:0] raw);
      logic [7:0] w;
      w = 8'hff & ~(raw & 8'h3f);
      if (raw[6]) w = w & 8'hef;
      if (raw[7]) w = w & 8'hdf;
      return w | 8'hc0;
   endfunction

   // A strobe edge advances the nibble phase; phase zero grabs the negated counts.
   function automatic void toggle_strobe(input logic lvl);
      if (strobe == lvl) return;
      strobe = lvl;
      if (phase == 2'd0) begin
         lat_x = 8'd0 - acc_x;
         lat_y = 8'd0 - acc_y;
         acc_x = '0;
         acc_y = '0;
      end
      phase = phase + 2'd1;
   endfunction

   function automatic logic [7:0] mouse_byte(input logic [1:0] sel);
      logic [3:0] n;
      case (phase)
         2'd1: n = lat_x[3:0];
         2'd2: n = lat_x[7:4];
         2'd3: n = lat_y[3:0];
         default: n = lat_y[7:4];
      endcase
      return {2'b11, sel & btn_up, n};
   endfunction

   function automatic logic [7:0] read_byte(input logic [1:0] addr);
      logic [7:0] raw;
      logic       hit;
      if (addr == ADDR_PORT) begin
         if (cfg_mode == MODE_PORT0) begin
            if (port_b[7:6] == 2'b00) return mouse_byte(port_b[1:0]);
         end else if (cfg_mode == MODE_PORT1) begin
            if (port_b[7:6] == 2'b01) return mouse_byte(port_b[3:2]);
         end
         if (port_b[7:4] == 4'h2 && cfg_prn != PRN_CH0) return joy_w[0];
         if (port_b[7:4] == 4'h5 && cfg_prn != PRN_CH1) return joy_w[1];
         return 8'hff;
      end
      // Printer joystick flag: any unmasked active line reads as zero.
      if ((addr == ADDR_PRN0 && cfg_prn == PRN_CH0) || (addr == ADDR_PRN1 && cfg_prn == PRN_CH1))
      begin
         raw = (addr == ADDR_PRN0) ? joy_raw[0] : joy_raw[1];
         hit = (raw[3] & ~prn_mask[0]) | (raw[2] & ~prn_mask[1]) | (raw[0] & ~prn_mask[2]) |
               (raw[1] & ~prn_mask[3]) | (raw[5] & ~prn_mask[4]) | (raw[4] & ~prn_mask[5]);
         if (hit) return 8'h00;
      end
      return 8'hff;
   endfunction

   // Applies one word to the model; returns 1 when the word yields a read byte.
   function automatic bit advance_port(input item_type w, output logic [7:0] rd);
      rd = 8'hff;
      case (w.cmd)
         CMD_FRAME: begin
            acc_x      = sat_sum(acc_x, w.dx);
            acc_y      = sat_sum(acc_y, w.dy);
            btn_up     = ~w.buttons;
            joy_raw[0] = w.joy0;
            joy_raw[1] = w.joy1;
            if (cfg_mode != MODE_PORT0) joy_w[0] = port_word(w.joy0);
            if (cfg_mode != MODE_PORT1) joy_w[1] = port_word(w.joy1);
         end
         CMD_PORT_B_WR: begin
            port_b = w.data;
            if (cfg_mode == MODE_PORT0) toggle_strobe(w.data[4]);
            else if (cfg_mode == MODE_PORT1) toggle_strobe(w.data[5]);
         end
         CMD_READ: begin
            rd = read_byte(w.addr);
            return 1'b1;
         end
         CMD_MASK_WR: begin
            if (cfg_prn == PRN_CH0 || cfg_prn == PRN_CH1) prn_mask = w.data[5:0];
         end
         CMD_TIMEOUT: begin
            phase  = '0;
            strobe = 1'b0;
            acc_x  = '0;
            acc_y  = '0;
            lat_x  = '0;
            lat_y  = '0;
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   task automatic flag_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
      $display("%0t: %s: got %02h, want %02h", $time, what, got, want);
      bad_count++;
   endtask

   // Offers one word with random gaps ahead of it and records the byte a read should return.
   task automatic send_word(input item_type w, input int pinned);
      logic [7:0] rd;
      while (!no_gaps && $urandom_range(99) < 28) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= w.cmd;
      req_tdata  <= {4'b0, w.data, w.addr, w.joy1, w.joy0, w.buttons, w.dy, w.dx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (advance_port(w, rd)) read_bytes_due.push_back(pinned >= 0 ? 8'(pinned) : rd);
   endtask

   // Register writes only go out once the port has drained.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [1:0] val);
      req_tvalid <= 1'b0;
      while (read_bytes_due.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_MOUSE_MODE) cfg_mode = val;
      else cfg_prn = val;
   endtask

   task automatic apply_setting(input logic [1:0] mode, input logic [1:0] prn);
      write_reg(CSR_MOUSE_MODE, mode);
      write_reg(CSR_PRN_USE, prn);
   endtask

   function automatic item_type random_word();
      item_type    w;
      logic [63:0] rnd;
      int          r;
      int          k;
      rnd = {$urandom(), $urandom()};
      w   = rnd[$bits(item_type)-1:0];
      r   = $urandom_range(99);
      if (r < 18) w.cmd = CMD_FRAME;
      else if (r < 45) w.cmd = CMD_PORT_B_WR;
      else if (r < 78) w.cmd = CMD_READ;
      else if (r < 86) w.cmd = CMD_MASK_WR;
      else if (r < 93) w.cmd = CMD_TIMEOUT;
      else w.cmd = 3'($urandom_range(CMD_SPARE5, CMD_SPARE7));
      // Port B bytes lean toward the mouse and joystick select patterns.
      if (w.cmd == CMD_PORT_B_WR) begin
         k = $urandom_range(9);
         if (k < 4) w.data[7:6] = 2'b00;
         else if (k < 7) w.data[7:6] = 2'b01;
         else if (k < 8) w.data[7:4] = 4'h2;
         else if (k < 9) w.data[7:4] = 4'h5;
      end
      return w;
   endfunction

   // Directed rows; a row with cfg set writes both registers first.
   typedef struct packed {
      bit         cfg;
      logic [1:0] mode;
      logic [1:0] prn;
      logic [2:0] cmd;
      logic [7:0] dx;
      logic [7:0] dy;
      logic [1:0] btn;
      logic [7:0] j0;
      logic [7:0] j1;
      logic [1:0] addr;
      logic [7:0] data;
      int         want;
   } dir_row_type;

   localparam int N_ROWS = 29;
   dir_row_type steps [N_ROWS] = '{
      '{1, MODE_NONE,  PRN_NONE,  CMD_READ,      0,     0,     0, 0,     0,     ADDR_PORT,  0,     'hff},
      '{0, MODE_NONE,  PRN_NONE,  CMD_READ,      0,     0,     0, 0,     0,     ADDR_SPARE, 0,     'hff},
      '{0, MODE_NONE,  PRN_NONE,  CMD_FRAME,     8'h7f, 8'h80, 3, 8'hff, 8'h00, ADDR_PORT,  0,     PREDICT},
      '{0, MODE_NONE,  PRN_NONE,  CMD_PORT_B_WR, 0,     0,     0, 0,     0,     ADDR_PORT,  8'h20, PREDICT},
      '{0, MODE_NONE,  PRN_NONE,  CMD_READ,      0,     0,     0, 0,     0,     ADDR_PORT,  0,     'hc0},
      '{0, MODE_NONE,  PRN_NONE,  CMD_PORT_B_WR, 0,     0,     0, 0,     0,     ADDR_PORT,  8'h50, PREDICT},
      '{0, MODE_NONE,  PRN_NONE,  CMD_READ,      0,     0,     0, 0,     0,     ADDR_PORT,  0,     'hff},
      '{0, MODE_NONE,  PRN_NONE,  CMD_FRAME,     0,     0,     0, 8'h40, 8'h80, ADDR_PORT,  0,     PREDICT},
      '{0, MODE_NONE,  PRN_NONE,  CMD_READ,      0,     0,     0, 0,     0,     ADDR_PORT,  0,     PREDICT},
      '{1, MODE_PORT0, PRN_CH0,   CMD_MASK_WR,   0,     0,     0, 0,     0,     ADDR_PORT,  8'h15, PREDICT},
      '{0, MODE_PORT0, PRN_CH0,   CMD_FRAME,     8'h80, 8'h7f, 1, 8'h0f, 8'h30, ADDR_PORT,  0,     PREDICT},
      '{0, MODE_PORT0, PRN_CH0,   CMD_PORT_B_WR, 0,     0,     0, 0,     0,     ADDR_PORT,  8'h13, PREDICT},
      '{0, MODE_PORT0, PRN_CH0,   CMD_READ,      0,     0,     0, 0,     0,     ADDR_PORT,  0,     PREDICT},
      '{0, MODE_PORT0, PRN_CH0,   CMD_PORT_B_WR, 0,     0,     0, 0,     0,     ADDR_PORT,  8'h03, PREDICT},
      '{0, MODE_PORT0, PRN_CH0,   CMD_READ,      0,     0,     0, 0,     0,     ADDR_PORT,  0,     PREDICT},
      '{0, MODE_PORT0, PRN_CH0,   CMD_READ,      0,     0,     0, 0,     0,     ADDR_PRN0,  0,     PREDICT},
      '{0, MODE_PORT0, PRN_CH0,   CMD_READ,      0,     0,     0, 0,     0,     ADDR_PRN1,  0,     'hff},
      '{0, MODE_PORT0, PRN_CH0,   CMD_TIMEOUT,   0,     0,     0, 0,     0,     ADDR_PORT,  0,     PREDICT},
      '{0, MODE_PORT0, PRN_CH0,   CMD_READ,      0,     0,     0, 0,     0,     ADDR_PORT,  0,     PREDICT},
      '{1, MODE_PORT1, PRN_CH1,   CMD_FRAME,     8'h7f, 8'h7f, 2, 8'haa, 8'h55, ADDR_PORT,  0,     PREDICT},
      '{0, MODE_PORT1, PRN_CH1,   CMD_PORT_B_WR, 0,     0,     0, 0,     0,     ADDR_PORT,  8'h6c, PREDICT},
      '{0, MODE_PORT1, PRN_CH1,   CMD_READ,      0,     0,     0, 0,     0,     ADDR_PORT,  0,     PREDICT},
      '{0, MODE_PORT1, PRN_CH1,   CMD_READ,      0,     0,     0, 0,     0,     ADDR_PRN1,  0,     PREDICT},
      '{1, MODE_SPARE, PRN_SPARE, CMD_MASK_WR,   0,     0,     0, 0,     0,     ADDR_PORT,  8'h3f, PREDICT},
      '{0, MODE_SPARE, PRN_SPARE, CMD_PORT_B_WR, 0,     0,     0, 0,     0,     ADDR_PORT,  8'h2c, PREDICT},
      '{0, MODE_SPARE, PRN_SPARE, CMD_READ,      0,     0,     0, 0,     0,     ADDR_PORT,  0,     PREDICT},
      '{0, MODE_SPARE, PRN_SPARE, CMD_SPARE5,    8'hff, 8'hff, 3, 8'hff, 8'hff, 2'd3,       8'hff, PREDICT},
      '{0, MODE_SPARE, PRN_SPARE, CMD_SPARE7,    8'hff, 8'hff, 3, 8'hff, 8'hff, 2'd3,       8'hff, PREDICT},
      '{0, MODE_SPARE, PRN_SPARE, CMD_READ,      0,     0,     0, 0,     0,     ADDR_PRN0,  0,     'hff}
   };

   // Random setting list: each mode and printer use, the extremes among them.
   localparam logic [1:0] PHASE_MODE [8] =
      '{MODE_PORT0, MODE_PORT1, MODE_NONE, MODE_SPARE, MODE_PORT0, MODE_PORT1, MODE_PORT0, MODE_PORT1};
   localparam logic [1:0] PHASE_PRN [8] =
      '{PRN_CH0, PRN_CH1, PRN_NONE, PRN_SPARE, PRN_CH1, PRN_CH0, PRN_NONE, PRN_SPARE};

   // Result stall, off during the stretch with no gaps.
   always @(posedge clock) begin
      rsp_tready <= no_gaps || ($urandom_range(99) >= 28);
   end

   // Read byte checker.
   always @(posedge clock) begin
      logic [7:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (read_bytes_due.size() == 0) begin
            flag_mismatch("read byte with none due", rsp_tdata, 8'h00);
         end else begin
            want = read_bytes_due.pop_front();
            if (rsp_tdata !== want) flag_mismatch("read_data", rsp_tdata, want);
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      item_type w;
      int       sent;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (steps[i]) begin
         if (steps[i].cfg) apply_setting(steps[i].mode, steps[i].prn);
         w = '{steps[i].cmd, steps[i].dx, steps[i].dy, steps[i].btn, steps[i].j0,
               steps[i].j1, steps[i].addr, steps[i].data};
         send_word(w, steps[i].want);
      end

      for (int p = 0; p < 8; p++) begin
         apply_setting(PHASE_MODE[p], PHASE_PRN[p]);
         no_gaps <= (p == 2);
         sent = 0;
         while (sent < 75) begin
            w = random_word();
            send_word(w, PREDICT);
            if (w.cmd <= CMD_TIMEOUT) sent++;
         end
      end

      req_tvalid <= 1'b0;
      no_gaps    <= 1'b0;
      while (read_bytes_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (bad_count == 0 && read_bytes_due.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
